### hw/rtl/imh_pkg.sv
// Shared types, codes and constants for the indexed min-heap block.
package imh_pkg;

    localparam int TILE_W       = 12;
    localparam int TILE_IDS     = 4096;
    localparam int KEY_W        = 24;
    localparam int COORD_W      = 6;
    localparam int DIM_W        = 7;
    localparam int CAPACITY_DEF = 4096;
    localparam int REG_WIDTH    = 0;
    localparam int REG_HEIGHT   = 1;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_SET  = 2'd2,
        OP_LOOK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC,
        S_UP_RD, S_UP_CMP,
        S_POP_CLR, S_POP_LAST,
        S_DN_RDL, S_DN_RDR, S_DN_CMP,
        S_MAP_CHK, S_HEAP_CHK,
        S_TOP_RD, S_TOP
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE, D_RUN, D_HOLD
    } t_dstate;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [KEY_W-1:0]   found_key;
        logic               top_valid;
        logic [TILE_W-1:0]  top_tile;
        logic [KEY_W-1:0]   top_key;
    } t_result;

endpackage

### hw/rtl/indexed_min_heap_decrease_key.sv
// Indexed min-heap top level: config registers, divider hand-off, output register.
// Results: the top tile id is split into column and row by the divider, then handed
//   into the output register.
// Throughput: one word at a time; the next is taken once sequencer and divider are idle.
// Reset (synchronous, active low): heap empty, grid 64 by 64, then the 4096-entry map is cleared.
module indexed_min_heap_decrease_key #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((64 + CW + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,  // pos_x, pos_y, key, zero pad
    input  logic [1:0]         s_tuser,  // op
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata   // status, top_valid, top_x, top_y, top_key,
                                         // found, found_key, entry_count, zero pad
);
    import imh_pkg::*;

    logic [DIM_W-1:0]  r_width, r_height;
    t_result           w_res, r_res;
    logic [CW-1:0]     w_count, r_count;
    logic              w_core_idle, w_core_done;
    logic              w_div_idle, w_div_done, w_take;
    logic [TILE_W-1:0] w_quot;
    logic [DIM_W-1:0]  w_rem;
    logic              r_mvalid;
    logic [OUT_W-1:0]  r_mdata;
    logic              w_wr;

    // config writes land on the access cycle; the pair of registers sits on paddr[2]
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(64);
            r_height <= DIM_W'(64);
        end else if (w_wr) begin
            if (paddr[2] == 1'(REG_HEIGHT)) begin
                r_height <= pwdata[DIM_W-1:0];
            end else begin
                r_width <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == 1'(REG_HEIGHT)) ? 32'(r_height) : 32'(r_width);

    // a word enters only when the sequencer and the divider are both free
    assign s_tready = w_core_idle && w_div_idle;

    imh_core #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_tvalid && s_tready),
        .i_op     (t_op'(s_tuser)),
        .i_x      (s_tdata[5:0]),
        .i_y      (s_tdata[11:6]),
        .i_key    (s_tdata[35:12]),
        .i_width  (r_width),
        .i_height (r_height),
        .o_idle   (w_core_idle),
        .o_done   (w_core_done),
        .o_res    (w_res),
        .o_count  (w_count)
    );

    // hold the heap result while the divider splits the top tile id
    always_ff @(posedge i_clk) begin
        if (w_core_done) begin
            r_res   <= w_res;
            r_count <= w_count;
        end
    end

    imh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_core_done),
        .i_take  (w_take),
        .i_num   (w_res.top_tile),
        .i_den   (r_width),
        .o_idle  (w_div_idle),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // output register frees the heap side; it loads when empty or being drained
    assign w_take = w_div_done && (!r_mvalid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_take) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mdata <= OUT_W'({r_count, r_res.found_key, r_res.found, r_res.top_key,
                               w_quot[COORD_W-1:0], w_rem[COORD_W-1:0],
                               r_res.top_valid, r_res.status});
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;

endmodule

### hw/rtl/imh_div.sv
// Restoring divider, one quotient bit per cycle: tile id into column and row.
module imh_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_take,
    input  logic [imh_pkg::TILE_W-1:0]  i_num,
    input  logic [imh_pkg::DIM_W-1:0]   i_den,
    output logic                        o_idle,
    output logic                        o_done,
    output logic [imh_pkg::TILE_W-1:0]  o_quot,
    output logic [imh_pkg::DIM_W-1:0]   o_rem
);
    import imh_pkg::*;

    localparam int CNT_W = $clog2(TILE_W + 1);

    t_dstate            r_state, n_state;
    logic [TILE_W-1:0]  r_q, n_q;
    logic [DIM_W-1:0]   r_rem, n_rem;
    logic [DIM_W-1:0]   r_den, n_den;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIM_W:0]     w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        w_trial = {r_rem, r_q[TILE_W-1]};
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_q     = i_num;
                    n_rem   = '0;
                    n_den   = i_den;
                    n_cnt   = CNT_W'(TILE_W);
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                n_q = {r_q[TILE_W-2:0], 1'b0};
                if (w_trial >= {1'b0, r_den}) begin
                    n_rem  = DIM_W'(w_trial - {1'b0, r_den});
                    n_q[0] = 1'b1;
                end else begin
                    n_rem = w_trial[DIM_W-1:0];
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = D_HOLD;
                end
            end
            D_HOLD: begin
                if (i_take) begin
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    // zero width gives zero coordinates
    assign o_idle = (r_state == D_IDLE);
    assign o_done = (r_state == D_HOLD);
    assign o_quot = (r_den == '0) ? '0 : r_q;
    assign o_rem  = (r_den == '0) ? '0 : r_rem;

endmodule

### hw/rtl/imh_core.sv
// Heap sequencer: heap and position-map memories, key compares, sift loops.
module imh_core #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  imh_pkg::t_op                i_op,
    input  logic [imh_pkg::COORD_W-1:0] i_x,
    input  logic [imh_pkg::COORD_W-1:0] i_y,
    input  logic [imh_pkg::KEY_W-1:0]   i_key,
    input  logic [imh_pkg::DIM_W-1:0]   i_width,
    input  logic [imh_pkg::DIM_W-1:0]   i_height,
    output logic                        o_idle,
    output logic                        o_done,
    output imh_pkg::t_result            o_res,
    output logic [CW-1:0]               o_count
);
    import imh_pkg::*;

    localparam int HW = TILE_W + KEY_W;

    // heap word {tile, key}; map word {valid, slot}
    logic [HW-1:0]  h_mem [CAPACITY];
    logic [AW:0]    m_mem [TILE_IDS];
    logic [HW-1:0]  r_hrd;
    logic [AW:0]    r_mrd;

    logic              h_we, m_we;
    logic [AW-1:0]     h_waddr, h_raddr;
    logic [HW-1:0]     h_wdata;
    logic [TILE_W-1:0] m_waddr, m_raddr;
    logic [AW:0]       m_wdata;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [COORD_W-1:0]  r_x, n_x, r_y, n_y;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [TILE_W-1:0]   r_tile, n_tile;
    logic [AW-1:0]       r_slot, n_slot, r_par, n_par;
    logic [CW-1:0]       r_size, n_size;
    logic [TILE_W-1:0]   r_ctile, n_ctile, r_ltile, n_ltile;
    logic [KEY_W-1:0]    r_ccost, n_ccost, r_lcost, n_lcost;
    logic [CW:0]         r_cidx, n_cidx;
    logic                r_hasr, n_hasr;
    t_status             r_status, n_status;
    logic                r_found, n_found;
    logic [KEY_W-1:0]    r_fkey, n_fkey;
    logic [TILE_W-1:0]   r_clr, n_clr;

    logic [TILE_W:0]     w_tile;
    logic                w_inrange;
    logic [CW:0]         w_c;
    logic [TILE_W-1:0]   w_htile;
    logic [KEY_W-1:0]    w_hcost;
    logic                w_right;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            h_mem[h_waddr] <= h_wdata;
        end
        r_hrd <= h_mem[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            m_mem[m_waddr] <= m_wdata;
        end
        r_mrd <= m_mem[m_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_size  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_x      <= n_x;
        r_y      <= n_y;
        r_key    <= n_key;
        r_tile   <= n_tile;
        r_slot   <= n_slot;
        r_par    <= n_par;
        r_ctile  <= n_ctile;
        r_ccost  <= n_ccost;
        r_ltile  <= n_ltile;
        r_lcost  <= n_lcost;
        r_cidx   <= n_cidx;
        r_hasr   <= n_hasr;
        r_status <= n_status;
        r_found  <= n_found;
        r_fkey   <= n_fkey;
    end

    assign w_tile    = (TILE_W+1)'(i_width) * (TILE_W+1)'(r_y) + (TILE_W+1)'(r_x);
    assign w_inrange = ({1'b0, r_x} < i_width) && ({1'b0, r_y} < i_height)
                       && (w_tile < (TILE_W+1)'(TILE_IDS));
    assign w_c       = (CW+1)'({r_slot, 1'b1});
    assign w_htile   = r_hrd[HW-1:KEY_W];
    assign w_hcost   = r_hrd[KEY_W-1:0];
    assign w_right   = r_hasr && (w_hcost < r_lcost);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_x      = r_x;
        n_y      = r_y;
        n_key    = r_key;
        n_tile   = r_tile;
        n_slot   = r_slot;
        n_par    = r_par;
        n_size   = r_size;
        n_ctile  = r_ctile;
        n_ccost  = r_ccost;
        n_ltile  = r_ltile;
        n_lcost  = r_lcost;
        n_cidx   = r_cidx;
        n_hasr   = r_hasr;
        n_status = r_status;
        n_found  = r_found;
        n_fkey   = r_fkey;
        n_clr    = r_clr;
        h_we     = 1'b0;
        h_waddr  = r_slot;
        h_wdata  = {r_ctile, r_ccost};
        h_raddr  = '0;
        m_we     = 1'b0;
        m_waddr  = r_ctile;
        m_wdata  = {1'b1, r_slot};
        m_raddr  = r_tile;

        case (r_state)
            S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_op;
                    n_x      = i_x;
                    n_y      = i_y;
                    n_key    = i_key;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_fkey   = '0;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_tile = w_tile[TILE_W-1:0];
                case (r_op)
                    OP_PUSH: begin
                        if (r_size >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_TOP_RD;
                        end else if (!w_inrange) begin
                            n_status = ST_RANGE;
                            n_state  = S_TOP_RD;
                        end else begin
                            n_slot  = r_size[AW-1:0];
                            n_size  = r_size + 1'b1;
                            n_ctile = w_tile[TILE_W-1:0];
                            n_ccost = r_key;
                            n_state = S_UP_RD;
                        end
                    end
                    OP_POP: begin
                        if (r_size == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_TOP_RD;
                        end else begin
                            h_raddr = '0;
                            n_state = S_POP_CLR;
                        end
                    end
                    default: begin
                        if (!w_inrange) begin
                            n_status = ST_EMPTY;
                            n_state  = S_TOP_RD;
                        end else begin
                            m_raddr = w_tile[TILE_W-1:0];
                            n_state = S_MAP_CHK;
                        end
                    end
                endcase
            end
            S_UP_RD: begin
                if (r_slot == '0) begin
                    h_we    = 1'b1;
                    m_we    = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    n_par   = AW'((r_slot - 1'b1) >> 1);
                    h_raddr = AW'((r_slot - 1'b1) >> 1);
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                h_we = 1'b1;
                m_we = 1'b1;
                if (r_ccost < w_hcost) begin
                    h_wdata = r_hrd;
                    m_waddr = w_htile;
                    n_slot  = r_par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_POP_CLR: begin
                // root's tile leaves the map; last entry moves up next
                m_we    = 1'b1;
                m_waddr = w_htile;
                m_wdata = '0;
                n_size  = r_size - 1'b1;
                h_raddr = AW'(r_size - 1'b1);
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                if (r_size == '0) begin
                    n_state = S_TOP_RD;
                end else begin
                    n_ctile = w_htile;
                    n_ccost = w_hcost;
                    n_slot  = '0;
                    n_state = S_DN_RDL;
                end
            end
            S_DN_RDL: begin
                if (w_c >= {1'b0, r_size}) begin
                    h_we    = 1'b1;
                    m_we    = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    h_raddr = w_c[AW-1:0];
                    n_cidx  = w_c;
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_ltile = w_htile;
                n_lcost = w_hcost;
                n_hasr  = (r_cidx + 1'b1) < {1'b0, r_size};
                h_raddr = AW'(r_cidx + 1'b1);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                h_we = 1'b1;
                m_we = 1'b1;
                if (w_right && (w_hcost < r_ccost)) begin
                    h_wdata = r_hrd;
                    m_waddr = w_htile;
                    n_slot  = AW'(r_cidx + 1'b1);
                    n_state = S_DN_RDL;
                end else if (!w_right && (r_lcost < r_ccost)) begin
                    h_wdata = {r_ltile, r_lcost};
                    m_waddr = r_ltile;
                    n_slot  = r_cidx[AW-1:0];
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_MAP_CHK: begin
                if (r_mrd[AW] && ((CW+1)'(r_mrd[AW-1:0]) < (CW+1)'(r_size))) begin
                    h_raddr = r_mrd[AW-1:0];
                    n_slot  = r_mrd[AW-1:0];
                    n_state = S_HEAP_CHK;
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_TOP_RD;
                end
            end
            S_HEAP_CHK: begin
                if (w_htile == r_tile) begin
                    n_found = 1'b1;
                    if (r_op == OP_SET) begin
                        n_fkey  = r_key;
                        n_ctile = r_tile;
                        n_ccost = r_key;
                        n_state = S_UP_RD;
                    end else begin
                        n_fkey  = w_hcost;
                        n_state = S_TOP_RD;
                    end
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                h_raddr = '0;
                n_state = S_TOP;
            end
            S_TOP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.status    = r_status;
        o_res.found     = r_found;
        o_res.found_key = r_fkey;
        o_res.top_valid = (r_size != '0);
        o_res.top_tile  = (r_size != '0) ? w_htile : '0;
        o_res.top_key   = (r_size != '0) ? w_hcost : '0;
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_done  = (r_state == S_TOP);
    assign o_count = r_size;

endmodule

### tb/testbench.sv
// Stream testbench for the indexed min-heap: predictor, driver, monitor and checks.
module testbench;
    import imh_pkg::*;

    localparam int HEAP_CAP   = 4096;
    localparam int WATCH_MAX  = 20000;  // covers the map clear after reset
    localparam int DRAIN_WAIT = 100;    // deepest pop plus the column/row split

    typedef struct {
        t_op        op;
        bit [5:0]   x;
        bit [5:0]   y;
        bit [23:0]  key;
    } t_heap_cmd;

    typedef struct {
        t_status    status;
        bit         top_valid;
        bit [5:0]   top_x;
        bit [5:0]   top_y;
        bit [23:0]  top_key;
        bit         found;
        bit [23:0]  found_key;
        bit [12:0]  count;
    } t_heap_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // pos_x, pos_y, key, zero pad
    logic [1:0]  s_tuser = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // status, top_valid, top_x, top_y, top_key,
                                 // found, found_key, entry_count, zero pad

    indexed_min_heap_decrease_key dut (.*);

    always #2 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    bit [11:0] slot_tile [HEAP_CAP];
    bit [23:0] slot_cost [HEAP_CAP];
    int        tile_slot [4096];
    bit        tile_held [4096];
    int        heap_count = 0;
    int        grid_w = 64, grid_h = 64;

    t_heap_cmd  pending_cmds[$];
    t_heap_view expected_views[$];
    t_heap_cmd  cur_cmd;
    int         words_sent = 0, words_taken = 0;
    int         mismatches = 0;
    int         gap_in = 0, gap_out = 0;
    bit         calm = 1'b0;     // no idling in the closing phase
    int         idle_cycles = 0;
    bit [5:0]   seen_x[$], seen_y[$];  // the last 64 tiles pushed, to aim set key/lookup at

    function automatic void put_slot(int s, bit [11:0] t, bit [23:0] c);
        slot_tile[s] = t;
        slot_cost[s] = c;
        tile_slot[t] = s;
        tile_held[t] = 1'b1;
    endfunction

    // strictly smaller child climbs
    function automatic void bubble_up(int s);
        bit [11:0] t;
        bit [23:0] c;
        int p;
        t = slot_tile[s];
        c = slot_cost[s];
        while (s != 0) begin
            p = (s - 1) / 2;
            if (c >= slot_cost[p]) break;
            put_slot(s, slot_tile[p], slot_cost[p]);
            s = p;
        end
        put_slot(s, t, c);
    endfunction

    // right child only when strictly below left
    function automatic void bubble_down(int s);
        bit [11:0] t;
        bit [23:0] c;
        int ch;
        t = slot_tile[s];
        c = slot_cost[s];
        forever begin
            ch = 2 * s + 1;
            if (ch >= heap_count) break;
            if (ch + 1 < heap_count && slot_cost[ch+1] < slot_cost[ch]) ch++;
            if (slot_cost[ch] >= c) break;
            put_slot(s, slot_tile[ch], slot_cost[ch]);
            s = ch;
        end
        put_slot(s, t, c);
    endfunction

    // slot of a live tile, -1 when outside the grid, absent or stale
    function automatic int locate_tile(bit [5:0] x, bit [5:0] y);
        int t;
        if (x >= grid_w || y >= grid_h) return -1;
        t = grid_w * y + x;
        if (t >= 4096 || !tile_held[t]) return -1;
        if (tile_slot[t] >= heap_count || slot_tile[tile_slot[t]] != t) return -1;
        return tile_slot[t];
    endfunction

    function automatic t_heap_view apply_heap_cmd(t_heap_cmd c);
        t_heap_view v;
        int s, t;
        v = '{status: ST_OK, default: 0};
        case (c.op)
            OP_PUSH: begin
                if (heap_count >= HEAP_CAP) v.status = ST_FULL;
                else if (c.x >= grid_w || c.y >= grid_h || grid_w * c.y + c.x >= 4096)
                    v.status = ST_RANGE;
                else begin
                    t = grid_w * c.y + c.x;
                    heap_count++;
                    put_slot(heap_count - 1, t[11:0], c.key);
                    bubble_up(heap_count - 1);
                end
            end
            OP_POP: begin
                if (heap_count == 0) v.status = ST_EMPTY;
                else begin
                    tile_held[slot_tile[0]] = 1'b0;
                    heap_count--;
                    if (heap_count != 0) begin
                        put_slot(0, slot_tile[heap_count], slot_cost[heap_count]);
                        bubble_down(0);
                    end
                end
            end
            default: begin
                s = locate_tile(c.x, c.y);
                if (s < 0) v.status = ST_EMPTY;
                else begin
                    v.found = 1'b1;
                    if (c.op == OP_SET) begin
                        slot_cost[s] = c.key;
                        v.found_key = c.key;
                        bubble_up(s);
                    end else v.found_key = slot_cost[s];
                end
            end
        endcase
        if (heap_count != 0) begin
            v.top_valid = 1'b1;
            if (grid_w != 0) begin
                v.top_x = 6'(slot_tile[0] % grid_w);
                v.top_y = 6'(slot_tile[0] / grid_w);
            end
            v.top_key = slot_cost[0];
        end
        v.count = 13'(heap_count);
        return v;
    endfunction

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h got %0h", name, e, a);
        end
    endtask

    // ---------------- driver: input side ----------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_tvalid && words_taken != words_sent)) begin
            if (!calm && gap_in > 0) begin
                s_tvalid <= 1'b0;
                gap_in <= gap_in - 1;
            end else if (pending_cmds.size() > 0) begin
                if (!calm && $urandom_range(0, 11) == 0) begin
                    gap_in <= $urandom_range(1, 14) - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata <= {4'd0, cur_cmd.key, cur_cmd.y, cur_cmd.x};
                    s_tuser <= cur_cmd.op;
                    s_tvalid <= 1'b1;
                    words_sent <= words_sent + 1;
                end
            end else s_tvalid <= 1'b0;
        end
    end

    // receiver stalls in bursts too
    always @(negedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else if (calm) m_tready <= 1'b1;
        else if (gap_out > 0) begin
            m_tready <= 1'b0;
            gap_out <= gap_out - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            gap_out <= $urandom_range(1, 14) - 1;
        end else m_tready <= 1'b1;
    end

    // ---------------- monitor: predict on accept, check on result ----------------
    always @(posedge i_clk) begin
        t_heap_view e;
        bit busy;
        busy = 1'b0;
        if (i_rst_n && s_tvalid && s_tready) begin
            expected_views.push_back(apply_heap_cmd(cur_cmd));
            words_taken <= words_taken + 1;
            busy = 1'b1;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            busy = 1'b1;
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result word with nothing expected");
            end else begin
                e = expected_views.pop_front();
                check_field("status",      e.status,    m_tdata[1:0]);
                check_field("top_valid",   e.top_valid, m_tdata[2]);
                check_field("top_x",       e.top_x,     m_tdata[8:3]);
                check_field("top_y",       e.top_y,     m_tdata[14:9]);
                check_field("top_key",     e.top_key,   m_tdata[38:15]);
                check_field("found",       e.found,     m_tdata[39]);
                check_field("found_key",   e.found_key, m_tdata[63:40]);
                check_field("entry_count", e.count,     m_tdata[76:64]);
            end
        end
        if (psel && penable) busy = 1'b1;
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(int idx, int val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx * 4); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_WIDTH) grid_w = val;
        else grid_h = val;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // hold the sender until everything is out, then let the block settle
    task automatic drain();
        while (pending_cmds.size() > 0 || words_sent != words_taken ||
               expected_views.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic queue_cmd(t_op op, int x, int y, int key);
        t_heap_cmd c;
        c.op = op; c.x = 6'(x); c.y = 6'(y); c.key = 24'(key);
        if (op == OP_PUSH) begin
            seen_x.push_back(c.x);
            seen_y.push_back(c.y);
            if (seen_x.size() > 64) begin
                void'(seen_x.pop_front());
                void'(seen_y.pop_front());
            end
        end
        pending_cmds.push_back(c);
    endtask

    function automatic int pick_key();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 24'hFFFFFF;
            2, 3:    return $urandom_range(0, 15);      // ties
            default: return $urandom & 24'hFFFFFF;
        endcase
    endfunction

    task automatic queue_random(int n);
        int r, k, x, y;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 8) begin
                x = $urandom_range(0, grid_w - 1);
                y = $urandom_range(0, grid_h - 1);
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
            end
            if (r >= 60 && seen_x.size() > 0 && $urandom_range(0, 9) < 6) begin
                k = $urandom_range(0, seen_x.size() - 1);
                x = seen_x[k];
                y = seen_y[k];
            end
            if (r < 40)      queue_cmd(OP_PUSH, x, y, pick_key());
            else if (r < 62) queue_cmd(OP_POP, x, y, pick_key());
            else if (r < 82) queue_cmd(OP_SET, x, y, pick_key());
            else             queue_cmd(OP_LOOK, x, y, pick_key());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default 64 by 64 grid
        queue_cmd(OP_POP, 0, 0, 0);              // pop when empty
        queue_cmd(OP_LOOK, 5, 5, 0);             // lookup when empty
        queue_cmd(OP_PUSH, 63, 63, 24'hFFFFFF);
        queue_cmd(OP_PUSH, 0, 0, 0);
        queue_cmd(OP_PUSH, 3, 3, 100);
        queue_cmd(OP_PUSH, 3, 3, 50);            // duplicate tile
        queue_cmd(OP_LOOK, 3, 3, 0);
        queue_cmd(OP_POP, 0, 0, 0);
        queue_cmd(OP_POP, 0, 0, 0);              // pops a copy of (3,3): map cleared
        queue_cmd(OP_LOOK, 3, 3, 0);             // stale, other copy still held
        queue_cmd(OP_SET, 63, 63, 1);            // decrease to top
        queue_cmd(OP_SET, 63, 63, 24'hFFFFF0);   // increase: no sift down
        queue_cmd(OP_LOOK, 63, 63, 0);
        queue_cmd(OP_PUSH, 42, 21, 24'h555555);
        queue_cmd(OP_PUSH, 21, 42, 24'hAAAAAA);
        queue_cmd(OP_SET, 10, 10, 7);            // absent tile
        drain();

        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 4);
        queue_cmd(OP_PUSH, 8, 0, 1);             // beyond width
        queue_cmd(OP_PUSH, 0, 4, 1);             // beyond height
        queue_cmd(OP_SET, 63, 63, 1);            // set key outside grid
        queue_cmd(OP_LOOK, 9, 2, 0);
        queue_random(300);
        drain();

        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 1);
        queue_random(200);
        drain();

        write_reg(REG_WIDTH, 64);
        write_reg(REG_HEIGHT, 1);
        queue_random(200);
        drain();

        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 64);
        queue_random(200);
        drain();

        write_reg(REG_WIDTH, 64);
        write_reg(REG_HEIGHT, 64);
        queue_random(300);
        drain();

        write_reg(REG_WIDTH, $urandom_range(2, 63));
        write_reg(REG_HEIGHT, $urandom_range(2, 63));
        queue_random(400);
        while (pending_cmds.size() > 120) @(posedge i_clk);
        calm = 1'b1;
        drain();

        if (mismatches == 0 && expected_views.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/imh_pkg.sv
hw/rtl/imh_div.sv
hw/rtl/imh_core.sv
hw/rtl/indexed_min_heap_decrease_key.sv
tb/testbench.sv
